// ===== rtl/core/nec_ir_pkg.sv =====
package nec_ir_pkg;

    localparam int TIME_W     = 16;
    localparam int CODE_W     = 32;
    localparam int CMD_W      = 8;
    localparam int CMD_LSB    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAME_BITS = 32;

    localparam logic [TIME_W-1:0] LEADER_MARK_MIN_RST  = 16'd8500;
    localparam logic [TIME_W-1:0] LEADER_MARK_MAX_RST  = 16'd9500;
    localparam logic [TIME_W-1:0] LEADER_SPACE_MIN_RST = 16'd4000;
    localparam logic [TIME_W-1:0] LEADER_SPACE_MAX_RST = 16'd5000;
    localparam logic [TIME_W-1:0] BURST_MIN_RST        = 16'd400;
    localparam logic [TIME_W-1:0] BURST_MAX_RST        = 16'd700;
    localparam logic [TIME_W-1:0] BIT_SPACE_MAX_RST    = 16'd1800;
    localparam logic [TIME_W-1:0] ONE_THRESHOLD_RST    = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEADER_MARK_MIN  = 3'd0,
        REG_LEADER_MARK_MAX  = 3'd1,
        REG_LEADER_SPACE_MIN = 3'd2,
        REG_LEADER_SPACE_MAX = 3'd3,
        REG_BURST_MIN        = 3'd4,
        REG_BURST_MAX        = 3'd5,
        REG_BIT_SPACE_MAX    = 3'd6,
        REG_ONE_THRESHOLD    = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BURST      = 3'd3,
        PH_SPACE      = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TIME_W-1:0] leader_mark_min;
        logic [TIME_W-1:0] leader_mark_max;
        logic [TIME_W-1:0] leader_space_min;
        logic [TIME_W-1:0] leader_space_max;
        logic [TIME_W-1:0] burst_min;
        logic [TIME_W-1:0] burst_max;
        logic [TIME_W-1:0] bit_space_max;
        logic [TIME_W-1:0] one_threshold;
    } cfg_t;

    typedef struct packed {
        logic              done;
        logic              aborted;
        logic [CODE_W-1:0] code;
    } result_t;

endpackage

// ===== rtl/core/nec_ir_cfg.sv =====
module nec_ir_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nec_ir_pkg::TIME_W-1:0]      cfg_data,
    output nec_ir_pkg::cfg_t                   cfg
);

    nec_ir_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_mark_min  <= nec_ir_pkg::LEADER_MARK_MIN_RST;
            cfg_reg.leader_mark_max  <= nec_ir_pkg::LEADER_MARK_MAX_RST;
            cfg_reg.leader_space_min <= nec_ir_pkg::LEADER_SPACE_MIN_RST;
            cfg_reg.leader_space_max <= nec_ir_pkg::LEADER_SPACE_MAX_RST;
            cfg_reg.burst_min        <= nec_ir_pkg::BURST_MIN_RST;
            cfg_reg.burst_max        <= nec_ir_pkg::BURST_MAX_RST;
            cfg_reg.bit_space_max    <= nec_ir_pkg::BIT_SPACE_MAX_RST;
            cfg_reg.one_threshold    <= nec_ir_pkg::ONE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (nec_ir_pkg::cfg_idx_t'(cfg_index))
                nec_ir_pkg::REG_LEADER_MARK_MIN:  cfg_reg.leader_mark_min  <= cfg_data;
                nec_ir_pkg::REG_LEADER_MARK_MAX:  cfg_reg.leader_mark_max  <= cfg_data;
                nec_ir_pkg::REG_LEADER_SPACE_MIN: cfg_reg.leader_space_min <= cfg_data;
                nec_ir_pkg::REG_LEADER_SPACE_MAX: cfg_reg.leader_space_max <= cfg_data;
                nec_ir_pkg::REG_BURST_MIN:        cfg_reg.burst_min        <= cfg_data;
                nec_ir_pkg::REG_BURST_MAX:        cfg_reg.burst_max        <= cfg_data;
                nec_ir_pkg::REG_BIT_SPACE_MAX:    cfg_reg.bit_space_max    <= cfg_data;
                nec_ir_pkg::REG_ONE_THRESHOLD:    cfg_reg.one_threshold    <= cfg_data;
                default:                          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/nec_ir_step.sv =====
module nec_ir_step
#(
    parameter int FRAME_BITS = nec_ir_pkg::FRAME_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           action,
    input  logic [nec_ir_pkg::TIME_W-1:0]  elapsed_us,
    input  nec_ir_pkg::cfg_t               cfg,
    output nec_ir_pkg::result_t            result
);

    localparam int CNT_W = $clog2(FRAME_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

    nec_ir_pkg::phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]                 bits_reg, bits_next;
    logic [nec_ir_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [nec_ir_pkg::CODE_W-1:0]    shifted;
    logic                             ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nec_ir_pkg::PH_IDLE;
            bits_reg  <= '0;
            code_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            code_reg  <= code_next;
        end
    end

    assign shifted = {code_reg[nec_ir_pkg::CODE_W-2:0],
                      (elapsed_us > cfg.one_threshold)};

    always_comb
    begin
        phase_next     = phase_reg;
        bits_next      = bits_reg;
        code_next      = code_reg;
        ok             = 1'b1;
        result.done    = 1'b0;
        result.aborted = 1'b0;
        result.code    = '0;
        case (phase_reg)
            nec_ir_pkg::PH_LEAD_MARK:
            begin
                ok = (elapsed_us > cfg.leader_mark_min) && (elapsed_us < cfg.leader_mark_max);
                phase_next = nec_ir_pkg::PH_LEAD_SPACE;
            end
            nec_ir_pkg::PH_LEAD_SPACE:
            begin
                ok = (elapsed_us > cfg.leader_space_min) && (elapsed_us < cfg.leader_space_max);
                phase_next = nec_ir_pkg::PH_BURST;
            end
            nec_ir_pkg::PH_BURST:
            begin
                ok = (elapsed_us >= cfg.burst_min) && (elapsed_us <= cfg.burst_max);
                phase_next = nec_ir_pkg::PH_SPACE;
            end
            nec_ir_pkg::PH_SPACE:
            begin
                ok = (elapsed_us > cfg.burst_min) && (elapsed_us < cfg.bit_space_max);
                code_next = shifted;
                if (bits_reg == LAST_BIT)
                begin
                    result.done = ok && !action;
                    result.code = (ok && !action) ? shifted : '0;
                    bits_next   = '0;
                    phase_next  = nec_ir_pkg::PH_IDLE;
                end
                else
                begin
                    bits_next  = bits_reg + 1'b1;
                    phase_next = nec_ir_pkg::PH_BURST;
                end
            end
            default:
            begin
                // Idle: an edge opens a frame, a timeout changes nothing.
                if (!action)
                begin
                    bits_next  = '0;
                    code_next  = '0;
                    phase_next = nec_ir_pkg::PH_LEAD_MARK;
                end
                else
                begin
                    phase_next = nec_ir_pkg::PH_IDLE;
                end
            end
        endcase

        // In an active phase a timeout or a failed width check drops the frame.
        if ((phase_reg == nec_ir_pkg::PH_LEAD_MARK) || (phase_reg == nec_ir_pkg::PH_LEAD_SPACE) ||
            (phase_reg == nec_ir_pkg::PH_BURST) || (phase_reg == nec_ir_pkg::PH_SPACE))
        begin
            if (action || !ok)
            begin
                phase_next     = nec_ir_pkg::PH_IDLE;
                bits_next      = bits_reg;
                code_next      = code_reg;
                result.aborted = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/nec_ir_pulse_decoder.sv =====
// NEC infrared pulse decoder.
// The input stream carries one event per beat: tdata holds the microseconds
// since the previous edge and tuser says whether the event is an edge (0) or
// a timer timeout (1). Every input beat produces exactly one output beat
// carrying the frame flags in tuser and, when a frame completed, the 32-bit
// code and its command byte in tdata.
// An accepted beat lands in an input register; the phase compares and the
// code shift are then evaluated from it and the outcome is loaded into the
// output register once the output side can take it. Both stages move every
// cycle, giving one beat per cycle when the receiver keeps tready high.
// When the receiver stalls, the output register holds its beat and the input
// register holds the next one; s_axis_tready drops only when both are full.
// The user must write the timing windows through cfg_we/cfg_index/cfg_data
// only while no beat is in flight; the decoder does not enforce this. Reset
// returns the decoder to idle with an empty code and loads the default NEC
// window limits.
module nec_ir_pulse_decoder
#(
    parameter int FRAME_BITS = nec_ir_pkg::FRAME_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] elapsed_us
    input  logic                              s_axis_tuser,   // [0] action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,   // [31:0] frame_code, [39:32] command_byte
    output logic [1:0]                        m_axis_tuser,   // [0] frame_done, [1] frame_aborted
    input  logic                              cfg_we,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nec_ir_pkg::TIME_W-1:0]     cfg_data
);

    nec_ir_pkg::cfg_t               cfg;
    nec_ir_pkg::result_t            result;

    logic                           in_valid_reg;
    logic                           in_action_reg;
    logic [nec_ir_pkg::TIME_W-1:0]  in_elapsed_reg;
    logic                           out_valid_reg;
    nec_ir_pkg::result_t            out_reg;
    logic                           advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    nec_ir_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nec_ir_step
    #(
        .FRAME_BITS (FRAME_BITS)
    )
    u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .action     (in_action_reg),
        .elapsed_us (in_elapsed_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg  <= s_axis_tuser;
            in_elapsed_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.code[nec_ir_pkg::CMD_LSB +: nec_ir_pkg::CMD_W], out_reg.code};
    assign m_axis_tuser  = {out_reg.aborted, out_reg.done};

endmodule
